// ===== hdl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helper functions of the differential-drive
// odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int ANGLE_WIDTH = 32;
   localparam int CNT_BITS    = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;

   localparam logic [31:0] HEADING_MASK = 32'hFFFF_FFFF << (32 - ANGLE_WIDTH);

   localparam int CORDIC_STEPS = 30;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
   localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
   localparam logic [31:0] US_PER_S       = 32'd1000000;

   localparam logic [31:0] DPC_RESET = 32'd1285212;
   localparam logic [24:0] SEP_RESET = 25'd32768;

   localparam int DIV_REM_W  = 40;
   localparam int DIV_QUOT_W = 47;
   localparam logic [5:0] DIV_STEPS_ROT = 6'd47;
   localparam logic [5:0] DIV_STEPS_VEL = 6'd31;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_DIST_PER_COUNT = 2'd0;
   localparam csr_index_type CSR_WHEEL_SEP      = 2'd1;

   typedef struct packed {
      logic signed [31:0] left_count;
      logic signed [31:0] right_count;
      logic [23:0]        elapsed_us;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x_out;
      logic signed [31:0] pos_y_out;
      logic [31:0]        heading_out;
      logic signed [31:0] quat_z;
      logic signed [31:0] quat_w;
      logic signed [31:0] linear_velocity;
      logic signed [31:0] angular_velocity;
   } rsp_type;

   typedef struct packed {
      logic [DIV_REM_W-1:0]  rem0;
      logic [DIV_QUOT_W-1:0] bits;
      logic [DIV_REM_W-1:0]  den;
      logic [5:0]            steps;
   } div_req_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TL_MUL, ST_TL_ACC, ST_TR_ACC, ST_MEAN,
      ST_ROT_START, ST_ROT_WAIT, ST_BA_LO, ST_BA_HI, ST_BA_SUM,
      ST_POS_START, ST_POS_WAIT, ST_STEP_XM, ST_STEP_X, ST_STEP_Y,
      ST_HEAD, ST_QUAT_START, ST_QUAT_WAIT,
      ST_VL_LO, ST_VL_HI, ST_VL_START, ST_VL_WAIT,
      ST_VA_LO, ST_VA_HI, ST_VA_START, ST_VA_WAIT, ST_OUT
   } state_type;

   function automatic logic [29:0] atan_lookup(input logic [4:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [32:0] sext_count(input logic [31:0] raw);
      logic [CNT_BITS-1:0] low;
      low = raw[CNT_BITS-1:0];
      return {{(33 - CNT_BITS){low[CNT_BITS-1]}}, low};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sd2147483647)
         r = 32'sh7FFF_FFFF;
      else if (v < -35'sd2147483648)
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

   // magnitude is at most 2^31
   function automatic logic signed [31:0] signed_vel(input logic [31:0] mag, input logic neg);
      logic [31:0] r;
      if (neg)
         r = 32'd0 - mag;
      else if (mag[31])
         r = 32'h7FFF_FFFF;
      else
         r = mag;
      return $signed(r);
   endfunction

endpackage

// ===== hdl/diff_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry
// The work is shorter when the mean travel is zero (no position CORDIC) or
// the elapsed time is zero (no velocity divisions). One request at a time:
// a request is taken only in idle, then runs through the bit-serial divider
// (47 + 2 x 31 steps), two 30-step CORDIC runs and a shared multiplier.
// Synchronous reset clears pose, heading, previous counts; CSRs reload.
// ----------------------------------------------------------------------------
module diff_drive_odometry (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ddo_pkg::req_type       req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ddo_pkg::rsp_type       rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  ddo_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_data
);
   import ddo_pkg::*;

   state_type state_ff, state_in;

   logic [31:0]        dpc_ff;
   logic [24:0]        sep_ff;
   logic signed [31:0] prev_l_ff, prev_r_ff;
   logic signed [31:0] pose_x_ff, pose_y_ff;
   logic [31:0]        heading_ff;
   logic [23:0]        dt_ff;
   logic signed [32:0] dl_ff, dr_ff;
   logic signed [48:0] tl_ff, tr_ff, mean_ff;
   logic [48:0]        dmag_ff;
   logic               rneg_ff;
   logic [47:0]        rot_mag_ff;
   logic [31:0]        rot_ba_ff;
   logic [63:0]        prod_ff, acc_ff;
   logic signed [31:0] trig_c_ff, trig_s_ff;
   logic signed [31:0] quat_z_ff, quat_w_ff, lin_vel_ff, ang_vel_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic [31:0]        mul_a, mul_b;
   logic signed [32:0] cur_l, cur_r;
   logic [32:0]        dl_abs, dr_abs;
   logic [63:0]        trav_round;
   logic signed [48:0] trav_signed;
   logic signed [49:0] tsum, tsum_adj, tdiff;
   logic [49:0]        tdiff_neg;
   logic [48:0]        mean_abs;
   logic [32:0]        dist_mag;
   logic [31:0]        tc_abs, ts_abs, trig_abs;
   logic               trig_neg;
   logic [63:0]        p_mag, p_round;
   logic signed [34:0] step_val, pose_sum;
   logic signed [31:0] pose_sel;
   logic [63:0]        ba_round;
   logic [31:0]        ba_mag;
   logic [69:0]        vel_n;
   logic [31:0]        vel_mag;
   logic [24:0]        sep_eff;
   logic [31:0]        heading_next, half_angle;
   logic               out_free;

   div_req_type        div_req;
   logic               div_start, div_done, div_sat;
   logic [DIV_QUOT_W-1:0] div_quot;
   logic               cordic_start, cordic_done;
   logic [31:0]        cordic_angle;
   logic signed [31:0] cordic_cos, cordic_sin;

   ddo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .req   (div_req),
      .done  (div_done),
      .sat   (div_sat),
      .quot  (div_quot)
   );

   ddo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (cordic_angle),
      .done    (cordic_done),
      .cos_out (cordic_cos),
      .sin_out (cordic_sin)
   );

   // ---- datapath helpers ----
   assign cur_l = sext_count(req_payload.left_count);
   assign cur_r = sext_count(req_payload.right_count);

   assign dl_abs = dl_ff[32] ? 33'(-dl_ff) : 33'(dl_ff);
   assign dr_abs = dr_ff[32] ? 33'(-dr_ff) : 33'(dr_ff);

   // travel = round(|diff| * dpc / 2^16), sign of the count difference
   assign trav_round  = prod_ff + 64'd32768;
   assign trav_signed = (state_ff == ST_TL_ACC ? dl_ff[32] : dr_ff[32])
                        ? -$signed({1'b0, trav_round[63:16]})
                        : $signed({1'b0, trav_round[63:16]});

   assign tsum      = {tl_ff[48], tl_ff} + {tr_ff[48], tr_ff};
   assign tsum_adj  = tsum + {49'd0, tsum[49]};
   assign tdiff     = {tr_ff[48], tr_ff} - {tl_ff[48], tl_ff};
   assign tdiff_neg = 50'(-tdiff);

   assign mean_abs = mean_ff[48] ? 49'(-mean_ff) : 49'(mean_ff);
   assign dist_mag = (mean_abs > 49'h1_0000_0000) ? 33'h1_0000_0000 : mean_abs[32:0];

   assign tc_abs   = trig_c_ff[31] ? 32'(-trig_c_ff) : 32'(trig_c_ff);
   assign ts_abs   = trig_s_ff[31] ? 32'(-trig_s_ff) : 32'(trig_s_ff);
   assign trig_abs = (state_ff == ST_STEP_X) ? tc_abs : ts_abs;
   assign trig_neg = (state_ff == ST_STEP_X) ? trig_c_ff[31] : trig_s_ff[31];
   assign pose_sel = (state_ff == ST_STEP_X) ? pose_x_ff : pose_y_ff;

   // |dist| is 2^32 only with a zero low word
   assign p_mag    = prod_ff + (dist_mag[32] ? {trig_abs, 32'd0} : 64'd0);
   assign p_round  = p_mag + 64'h2000_0000;
   assign step_val = (mean_ff[48] ^ trig_neg) ? -$signed({1'b0, p_round[63:30]})
                                              : $signed({1'b0, p_round[63:30]});
   assign pose_sum = {{3{pose_sel[31]}}, pose_sel} + step_val;

   assign ba_round = prod_ff + 64'h8000_0000;
   assign ba_mag   = prod_ff[31:0] + acc_ff[31:0];

   assign vel_n   = {6'd0, acc_ff} + {prod_ff[37:0], 32'd0};
   assign vel_mag = div_sat ? 32'h8000_0000 : {1'b0, div_quot[30:0]};

   assign sep_eff      = (sep_ff == 25'd0) ? 25'd1 : sep_ff;
   assign heading_next = (heading_ff + rot_ba_ff) & HEADING_MASK;
   assign half_angle   = {1'b0, heading_ff[31:1]} + {heading_ff[31], 31'd0};
   assign cordic_angle = (state_ff == ST_POS_START) ? heading_ff - rot_ba_ff : half_angle;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_TL_MUL: begin
            mul_a = dl_abs[31:0];
            mul_b = dpc_ff;
         end
         ST_TL_ACC: begin
            mul_a = dr_abs[31:0];
            mul_b = dpc_ff;
         end
         ST_BA_LO, ST_VA_LO: begin
            mul_a = rot_mag_ff[31:0];
            mul_b = (state_ff == ST_BA_LO) ? INV_TWO_PI_Q32 : US_PER_S;
         end
         ST_BA_HI, ST_VA_HI: begin
            mul_a = {16'd0, rot_mag_ff[47:32]};
            mul_b = (state_ff == ST_BA_HI) ? INV_TWO_PI_Q32 : US_PER_S;
         end
         ST_STEP_XM: begin
            mul_a = dist_mag[31:0];
            mul_b = tc_abs;
         end
         ST_STEP_X: begin
            mul_a = dist_mag[31:0];
            mul_b = ts_abs;
         end
         ST_VL_LO: begin
            mul_a = mean_abs[31:0];
            mul_b = US_PER_S;
         end
         ST_VL_HI: begin
            mul_a = {15'd0, mean_abs[48:32]};
            mul_b = US_PER_S;
         end
         default: ;
      endcase
   end

   // divider request select
   always_comb begin
      div_req.rem0  = {vel_n[69:31], 1'b0} >> 1;
      div_req.bits  = {vel_n[30:0], 16'd0};
      div_req.den   = {16'd0, dt_ff};
      div_req.steps = DIV_STEPS_VEL;
      if (state_ff == ST_ROT_START) begin
         div_req.rem0  = {6'd0, dmag_ff[48:15]};
         div_req.bits  = {dmag_ff[14:0], 32'd0};
         div_req.den   = {15'd0, sep_eff};
         div_req.steps = DIV_STEPS_ROT;
      end else if (state_ff == ST_VA_START) begin
         div_req.den = {dt_ff, 16'd0};
      end
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      div_start    = 1'b0;
      cordic_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid)
               state_in = ST_TL_MUL;
         end
         ST_TL_MUL:    state_in = ST_TL_ACC;
         ST_TL_ACC:    state_in = ST_TR_ACC;
         ST_TR_ACC:    state_in = ST_MEAN;
         ST_MEAN:      state_in = ST_ROT_START;
         ST_ROT_START: begin
            div_start = 1'b1;
            state_in  = ST_ROT_WAIT;
         end
         ST_ROT_WAIT:  if (div_done) state_in = ST_BA_LO;
         ST_BA_LO:     state_in = ST_BA_HI;
         ST_BA_HI:     state_in = ST_BA_SUM;
         ST_BA_SUM:    state_in = (mean_ff != '0) ? ST_POS_START : ST_HEAD;
         ST_POS_START: begin
            cordic_start = 1'b1;
            state_in     = ST_POS_WAIT;
         end
         ST_POS_WAIT:  if (cordic_done) state_in = ST_STEP_XM;
         ST_STEP_XM:   state_in = ST_STEP_X;
         ST_STEP_X:    state_in = ST_STEP_Y;
         ST_STEP_Y:    state_in = ST_HEAD;
         ST_HEAD:      state_in = ST_QUAT_START;
         ST_QUAT_START: begin
            cordic_start = 1'b1;
            state_in     = ST_QUAT_WAIT;
         end
         ST_QUAT_WAIT: if (cordic_done) state_in = (dt_ff == '0) ? ST_OUT : ST_VL_LO;
         ST_VL_LO:     state_in = ST_VL_HI;
         ST_VL_HI:     state_in = ST_VL_START;
         ST_VL_START: begin
            div_start = 1'b1;
            state_in  = ST_VL_WAIT;
         end
         ST_VL_WAIT:   if (div_done) state_in = ST_VA_LO;
         ST_VA_LO:     state_in = ST_VA_HI;
         ST_VA_HI:     state_in = ST_VA_START;
         ST_VA_START: begin
            div_start = 1'b1;
            state_in  = ST_VA_WAIT;
         end
         ST_VA_WAIT:   if (div_done) state_in = ST_OUT;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // ---- architectural state and registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff     <= DPC_RESET;
         sep_ff     <= SEP_RESET;
         prev_l_ff  <= '0;
         prev_r_ff  <= '0;
         pose_x_ff  <= '0;
         pose_y_ff  <= '0;
         heading_ff <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_DIST_PER_COUNT)
               dpc_ff <= csr_data;
            else if (csr_index == CSR_WHEEL_SEP)
               sep_ff <= csr_data[24:0];
         end
         if (state_ff == ST_IDLE && req_valid) begin
            prev_l_ff <= cur_l[31:0];
            prev_r_ff <= cur_r[31:0];
         end
         if (state_ff == ST_STEP_X)
            pose_x_ff <= sat32(pose_sum);
         if (state_ff == ST_STEP_Y)
            pose_y_ff <= sat32(pose_sum);
         if (state_ff == ST_HEAD)
            heading_ff <= heading_next;
      end
   end

   // ---- working registers ----
   always_ff @(posedge clock) begin
      prod_ff <= {32'd0, mul_a} * {32'd0, mul_b};
      unique case (state_ff)
         ST_IDLE: begin
            dl_ff <= $signed({prev_l_ff[31], prev_l_ff}) - cur_l;
            dr_ff <= $signed({prev_r_ff[31], prev_r_ff}) - cur_r;
            dt_ff <= req_payload.elapsed_us;
         end
         ST_TL_ACC: tl_ff <= trav_signed;
         ST_TR_ACC: tr_ff <= trav_signed;
         ST_MEAN: begin
            mean_ff <= tsum_adj[49:1];
            rneg_ff <= tdiff[49];
            dmag_ff <= tdiff[49] ? tdiff_neg[48:0] : tdiff[48:0];
         end
         ST_ROT_WAIT:
            if (div_done)
               rot_mag_ff <= div_sat ? 48'h8000_0000_0000 : {1'b0, div_quot};
         ST_BA_HI: acc_ff <= {32'd0, ba_round[63:32]};
         ST_BA_SUM: rot_ba_ff <= rneg_ff ? 32'd0 - ba_mag : ba_mag;
         ST_POS_WAIT:
            if (cordic_done) begin
               trig_c_ff <= cordic_cos;
               trig_s_ff <= cordic_sin;
            end
         ST_QUAT_WAIT:
            if (cordic_done) begin
               quat_z_ff  <= cordic_sin;
               quat_w_ff  <= cordic_cos;
               lin_vel_ff <= '0;
               ang_vel_ff <= '0;
            end
         ST_VL_HI, ST_VA_HI: acc_ff <= prod_ff;
         ST_VL_WAIT: if (div_done) lin_vel_ff <= signed_vel(vel_mag, mean_ff[48]);
         ST_VA_WAIT: if (div_done) ang_vel_ff <= signed_vel(vel_mag, rneg_ff);
         default: ;
      endcase
   end

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_ff.pos_x_out        <= pose_x_ff;
         rsp_ff.pos_y_out        <= pose_y_ff;
         rsp_ff.heading_out      <= heading_ff;
         rsp_ff.quat_z           <= quat_z_ff;
         rsp_ff.quat_w           <= quat_w_ff;
         rsp_ff.linear_velocity  <= lin_vel_ff;
         rsp_ff.angular_velocity <= ang_vel_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

endmodule

// ===== hdl/ddo_div.sv =====
// ----------------------------------------------------------------------------
// ddo_div
// Restoring divider, one quotient bit per cycle. The caller supplies the
// upper part of the dividend as the initial remainder; sat flags that the
// quotient would not fit in the requested number of bits.
// ----------------------------------------------------------------------------
module ddo_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  ddo_pkg::div_req_type       req,
   output logic                       done,
   output logic                       sat,
   output logic [ddo_pkg::DIV_QUOT_W-1:0] quot
);
   import ddo_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic                  sat_ff;
   logic [5:0]            cnt_ff;
   logic [DIV_REM_W-1:0]  rem_ff;
   logic [DIV_REM_W-1:0]  den_ff;
   logic [DIV_QUOT_W-1:0] bits_ff;
   logic [DIV_QUOT_W-1:0] quot_ff;
   logic [DIV_REM_W:0]    shifted;
   logic [DIV_REM_W+1:0]  trial;

   assign shifted = {rem_ff, bits_ff[DIV_QUOT_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 6'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= req.rem0;
         bits_ff <= req.bits;
         den_ff  <= req.den;
         cnt_ff  <= req.steps;
         quot_ff <= '0;
         sat_ff  <= (req.rem0 >= req.den);
      end else if (busy_ff) begin
         if (!trial[DIV_REM_W+1])
            rem_ff <= trial[DIV_REM_W-1:0];
         else
            rem_ff <= shifted[DIV_REM_W-1:0];
         quot_ff <= {quot_ff[DIV_QUOT_W-2:0], ~trial[DIV_REM_W+1]};
         bits_ff <= {bits_ff[DIV_QUOT_W-2:0], 1'b0};
         cnt_ff  <= cnt_ff - 6'd1;
      end
   end

   assign done = done_ff;
   assign sat  = sat_ff;
   assign quot = quot_ff;

endmodule

// ===== hdl/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC on a 32-bit binary angle: quadrant fold,
// one micro-rotation per cycle, clamp to unit range, quadrant restore.
// ----------------------------------------------------------------------------
module ddo_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic               done,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out
);
   import ddo_pkg::*;

   logic               busy_ff;
   logic               done_ff;
   logic [4:0]         step_ff;
   logic [1:0]         quad_ff;
   logic signed [33:0] x_ff;
   logic signed [33:0] y_ff;
   logic signed [33:0] z_ff;
   logic signed [33:0] xs;
   logic signed [33:0] ys;
   logic signed [33:0] atan_ext;
   logic [31:0]        biased;
   logic [31:0]        folded;
   logic signed [33:0] xc;
   logic signed [33:0] yc;
   logic signed [31:0] xo;
   logic signed [31:0] yo;

   function automatic logic signed [33:0] clamp_unit(input logic signed [33:0] v);
      logic signed [33:0] r;
      if (v > ONE_Q30)
         r = ONE_Q30;
      else if (v < -ONE_Q30)
         r = -ONE_Q30;
      else
         r = v;
      return r;
   endfunction

   assign biased   = angle + 32'h2000_0000;
   assign folded   = angle - {biased[31:30], 30'd0};
   assign xs       = x_ff >>> step_ff;
   assign ys       = y_ff >>> step_ff;
   assign atan_ext = $signed({4'd0, atan_lookup(step_ff)});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quad_ff <= biased[31:30];
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= $signed({{2{folded[31]}}, folded});
         step_ff <= '0;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_ext;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_ext;
         end
         step_ff <= step_ff + 5'd1;
      end
   end

   assign xc = clamp_unit(x_ff);
   assign yc = clamp_unit(y_ff);
   assign xo = xc[31:0];
   assign yo = yc[31:0];

   always_comb begin
      unique case (quad_ff)
         2'd0: begin
            cos_out = xo;
            sin_out = yo;
         end
         2'd1: begin
            cos_out = -yo;
            sin_out = xo;
         end
         2'd2: begin
            cos_out = -xo;
            sin_out = -yo;
         end
         default: begin
            cos_out = yo;
            sin_out = -xo;
         end
      endcase
   end

   assign done = done_ff;

endmodule

// ===== hdl/ddo_checker.sv =====
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks on the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module ddo_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input ddo_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ddo_pkg::rsp_type rsp_payload
);
   import ddo_pkg::*;

   // a result that is not taken stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("stalled result changed");

   // one request at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // a waiting request is held unchanged
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("waiting request changed");

   // both quaternion parts stay in unit range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.quat_w <= 32'sd1073741824
                    && rsp_payload.quat_w >= -32'sd1073741824
                    && rsp_payload.quat_z <= 32'sd1073741824
                    && rsp_payload.quat_z >= -32'sd1073741824)
      else $error("quaternion out of range");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);

// ===== tb/tb_diff_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry
// Drives encoder ticks through the odometry block under random stalls on both
// channels and checks every pose, quaternion and velocity result against an
// in-bench fixed-point model, over several register settings.
// ----------------------------------------------------------------------------
module tb_diff_drive_odometry;
   import ddo_pkg::*;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_payload;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_type       rsp_payload;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [31:0]   csr_data;

   diff_drive_odometry DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   localparam longint ARC_TAB [30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};
   localparam longint Q30_ONE = 64'sd1073741824;

   // model state
   longint unsigned m_dpc, m_sep;
   longint          m_prev_l, m_prev_r, m_px, m_py;
   logic [31:0]     m_heading;

   req_type pending_ticks[$];
   rsp_type expected_poses[$];
   int      errors;
   bit      no_gaps;
   int      tx_gap, rx_stall;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void cordic_sincos(input logic [31:0] ang, output longint c,
                                         output longint s);
      logic [31:0] quad, rr;
      longint z, x, y, xs, ys;
      quad = ((ang + 32'h2000_0000) >> 30) & 32'd3;
      rr = ang - (quad << 30);
      z = longint'($signed(rr));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= ARC_TAB[i];
         end else begin
            x += ys; y -= xs; z += ARC_TAB[i];
         end
      end
      x = clip(x, -Q30_ONE, Q30_ONE);
      y = clip(y, -Q30_ONE, Q30_ONE);
      case (quad[1:0])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint travel(input longint dc);
      longint unsigned mag, t;
      mag = dc < 0 ? -dc : dc;
      t = (mag * m_dpc + 64'd32768) >> 16;
      return dc < 0 ? -longint'(t) : longint'(t);
   endfunction

   function automatic longint q30_step(input longint step_len, input longint trig);
      longint p;
      longint unsigned m;
      longint r;
      p = step_len * trig;
      m = p < 0 ? -p : p;
      r = longint'((m + (64'd1 << 29)) >> 30);
      return p < 0 ? -r : r;
   endfunction

   function automatic longint unsigned vel_mag(input longint unsigned mag,
                                               input longint unsigned dv);
      longint unsigned q, r, res;
      q = mag / dv;
      r = mag % dv;
      if (q >= 64'h8000_0000) return 64'h8000_0000;
      res = q * 64'd1000000 + (r * 64'd1000000) / dv;
      return res > 64'h8000_0000 ? 64'h8000_0000 : res;
   endfunction

   function automatic logic [31:0] vel_field(input longint unsigned mag, input bit neg);
      if (neg) return 32'd0 - mag[31:0];
      return mag > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : mag[31:0];
   endfunction

   function automatic rsp_type odometry_update(input req_type t);
      longint          cl, cr, tl, tr, mean, diff, step_len, c, s;
      longint unsigned dmag, q, r, rot_mag, ba, mm, dt, sep;
      logic [31:0]     rot_ba, half;
      bit              rneg;
      rsp_type         o;
      cl = longint'(t.left_count);
      cr = longint'(t.right_count);
      dt = t.elapsed_us;
      sep = m_sep == 0 ? 1 : m_sep;
      tl = travel(m_prev_l - cl);
      tr = travel(m_prev_r - cr);
      m_prev_l = cl;
      m_prev_r = cr;
      mean = (tl + tr) / 2;
      diff = tr - tl;
      rneg = diff < 0;
      dmag = rneg ? -diff : diff;
      q = dmag / sep;
      r = dmag % sep;
      if (q >= 32768) rot_mag = 64'd1 << 47;
      else rot_mag = (q << 32) + ((r << 32) / sep);
      ba = (rot_mag >> 32) * 64'd683565276
           + (((rot_mag & 64'hFFFF_FFFF) * 64'd683565276 + 64'h8000_0000) >> 32);
      rot_ba = ba[31:0];
      if (rneg) rot_ba = 32'd0 - rot_ba;
      if (mean != 0) begin
         step_len = clip(mean, -(64'sd1 <<< 32), 64'sd1 <<< 32);
         cordic_sincos(m_heading - rot_ba, c, s);
         m_px = clip(m_px + q30_step(step_len, c), -64'sd2147483648, 64'sd2147483647);
         m_py = clip(m_py + q30_step(step_len, s), -64'sd2147483648, 64'sd2147483647);
      end
      m_heading = (m_heading + rot_ba) & HEADING_MASK;
      half = (m_heading >> 1) + (m_heading & 32'h8000_0000);
      cordic_sincos(half, c, s);
      o.pos_x_out   = m_px[31:0];
      o.pos_y_out   = m_py[31:0];
      o.heading_out = m_heading;
      o.quat_z      = s[31:0];
      o.quat_w      = c[31:0];
      if (dt == 0) begin
         o.linear_velocity  = '0;
         o.angular_velocity = '0;
      end else begin
         mm = mean < 0 ? -mean : mean;
         o.linear_velocity  = vel_field(vel_mag(mm, dt), mean < 0);
         o.angular_velocity = vel_field(vel_mag(rot_mag, dt << 16), rneg);
      end
      return o;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
      end else if (!req_valid || req_ready) begin
         if (tx_gap > 0) begin
            tx_gap--;
            req_valid <= 1'b0;
         end else if (pending_ticks.size() > 0) begin
            req_payload <= pending_ticks.pop_front();
            req_valid <= 1'b1;
            tx_gap = no_gaps ? 0 : $urandom_range(0, 16);
         end else
            req_valid <= 1'b0;
      end
   end

   // request monitor feeds the model
   always @(posedge clock)
      if (!reset && req_valid && req_ready)
         expected_poses.push_back(odometry_update(req_payload));

   // result side: stall draw and compare
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rx_stall = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_poses.size() == 0) begin
               errors++;
               $display("%0t unexpected result, expected none actual %h", $time,
                        rsp_payload);
            end else begin
               e = expected_poses.pop_front();
               check_field("pos_x", e.pos_x_out, rsp_payload.pos_x_out);
               check_field("pos_y", e.pos_y_out, rsp_payload.pos_y_out);
               check_field("heading", e.heading_out, rsp_payload.heading_out);
               check_field("quat_z", e.quat_z, rsp_payload.quat_z);
               check_field("quat_w", e.quat_w, rsp_payload.quat_w);
               check_field("lin_vel", e.linear_velocity, rsp_payload.linear_velocity);
               check_field("ang_vel", e.angular_velocity, rsp_payload.angular_velocity);
            end
            rx_stall = no_gaps ? 0 : $urandom_range(0, 16);
         end else if (rx_stall > 0)
            rx_stall--;
         rsp_ready <= (rx_stall == 0);
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DIST_PER_COUNT) m_dpc = val;
      else if (idx == CSR_WHEEL_SEP) m_sep = val & 32'h1FF_FFFF;
      csr_valid <= 1'b0;
   endtask

   // sampled away from the driving edge so queue and valid are settled
   task automatic drain();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_valid || expected_poses.size() != 0);
   endtask

   logic signed [31:0] gen_l, gen_r;

   task automatic add_tick(input logic signed [31:0] l, input logic signed [31:0] r,
                           input logic [23:0] us);
      req_type t;
      t.left_count  = l;
      t.right_count = r;
      t.elapsed_us  = us;
      gen_l = l;
      gen_r = r;
      pending_ticks.push_back(t);
   endtask

   task automatic add_random_ticks(input int n);
      int          d, kind;
      logic [23:0] us;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 99);
         case ($urandom_range(0, 9))
            0: us = 0;
            1: us = 24'($urandom_range(1, 5));
            2: us = 24'($urandom);
            default: us = 24'($urandom_range(50000, 150000));
         endcase
         if (kind < 60)
            add_tick(gen_l + $signed($urandom_range(0, 4000)) - 2000,
                     gen_r + $signed($urandom_range(0, 4000)) - 2000, us);
         else if (kind < 75) begin
            d = $signed($urandom_range(0, 4000)) - 2000;
            add_tick(gen_l + d, gen_r + d, us);
         end else if (kind < 85) begin
            d = $signed($urandom_range(0, 2000)) - 1000;
            add_tick(gen_l + d, gen_r - d, us);
         end else if (kind < 92)
            add_tick(gen_l + $signed($urandom) / 64, gen_r + $signed($urandom) / 64, us);
         else
            add_tick($urandom, $urandom, us);
      end
   endtask

   initial begin
      errors = 0;
      no_gaps = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_DIST_PER_COUNT;
      csr_data = '0;
      m_dpc = DPC_RESET;
      m_sep = SEP_RESET;
      m_prev_l = 0; m_prev_r = 0; m_px = 0; m_py = 0; m_heading = 0;
      gen_l = 0; gen_r = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero mean, spins, zero and tiny time
      add_tick(0, 0, 0);
      add_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFF_FFFF);
      add_tick(32'sh8000_0000, 32'sh8000_0000, 1);
      add_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 1);
      add_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      add_tick(-1000, -1000, 100000);
      add_tick(-900, -1100, 100000);
      add_tick(-900, -1100, 100000);
      add_tick(0, 0, 1);
      add_tick(500, -500, 100000);
      drain();

      csr_write(CSR_WHEEL_SEP, 0);
      csr_write(CSR_DIST_PER_COUNT, 32'hFFFF_FFFF);
      add_tick(1000, -1000, 1);
      add_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 1);
      add_tick(0, 0, 24'hFF_FFFF);
      add_tick(-5, 5, 0);
      drain();

      csr_write(CSR_WHEEL_SEP, 1);
      csr_write(CSR_DIST_PER_COUNT, 1);
      add_tick(-3, 3, 7);
      add_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 1);
      drain();

      csr_write(CSR_WHEEL_SEP, 16777216);
      csr_write(CSR_DIST_PER_COUNT, 32'hFFFF_FFFF);
      add_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 3);
      add_tick(12345, -54321, 100000);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin csr_write(CSR_DIST_PER_COUNT, DPC_RESET);
                     csr_write(CSR_WHEEL_SEP, SEP_RESET); end
            1: begin csr_write(CSR_DIST_PER_COUNT, 1);
                     csr_write(CSR_WHEEL_SEP, 1); end
            2: begin csr_write(CSR_DIST_PER_COUNT, 32'hFFFF_FFFF);
                     csr_write(CSR_WHEEL_SEP, 16777216); end
            3: csr_write(CSR_WHEEL_SEP, 0);
            default: begin csr_write(CSR_DIST_PER_COUNT, $urandom);
                     csr_write(CSR_WHEEL_SEP, $urandom_range(1, 200000)); end
         endcase
         no_gaps = (ph == 5);
         add_random_ticks(178);
         // hold the next phase until the block has emptied
         drain();
      end
      no_gaps = 1'b0;

      repeat (300) @(posedge clock);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #40000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
